// File: sv/tlpqs_pkg.sv
package tlpqs_pkg;

  localparam int TIME_BITS = 32;

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic CLASS_USER   = 1'b0;
  localparam logic CLASS_SYSTEM = 1'b1;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// File: sv/two_level_preemptive_queue_scheduler.sv
// Two-level preemptive task scheduler, one time unit per tick item.
// Input stream (s_*): tuser selects the item kind, arrival or tick. An
// arrival puts (task_id, burst_len) at the tail of the system or user queue
// and gives no result; a full queue drops it and sets the sticky overflow
// flag. A tick preempts a running user task when system work waits and
// the user queue has room, fills an idle slot from the system queue first,
// runs the chosen task one unit and gives one result item on m_*.
// Flow: an arrival is taken in ST_IDLE and the stream stays ready for the
// next item; a tick drops s_tready until its update in ST_TICK, as the
// queue memories read through a register (head read on accept).
// The result sits in an output register; a tick is accepted while an
// earlier result still waits, and its update cycle holds until that
// register drains. Arrivals wait on a stalled receiver only behind a tick.
// Reset (rst, synchronous): queues empty, no task running, time zero,
// overflow clear. Queue memory contents are not cleared.
module two_level_preemptive_queue_scheduler #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_BITS     = 16,
  parameter int BURST_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // task_id, burst_len, is_system, zero pad
  input  logic [((ID_BITS + BURST_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  // cmd
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // busy_res, running_id, slot_time, finished, overflow_seen, zero pad
  output logic [((ID_BITS + tlpqs_pkg::TIME_BITS + 3 + 7) / 8) * 8 - 1:0] m_tdata
);
  import tlpqs_pkg::*;

  localparam int EW    = ID_BITS + BURST_BITS;
  localparam int OUT_W = ((ID_BITS + TIME_BITS + 3 + 7) / 8) * 8;

  typedef enum logic {ST_IDLE, ST_TICK} state_t;

  state_t                state;
  logic                  run_valid;
  logic                  run_sys;
  logic [ID_BITS-1:0]    run_id;
  logic [BURST_BITS-1:0] run_rem;
  logic [TIME_BITS-1:0]  clock_time;
  logic                  overflow;

  logic                  accept, arrival, tick_req, tick_go;
  logic [ID_BITS-1:0]    in_id;
  logic [BURST_BITS-1:0] in_burst, in_rem;
  logic                  in_sys;
  logic [EW-1:0]         in_entry, user_wdata, sys_rdata, user_rdata;
  q_ctrl_t               sys_ctrl, user_ctrl;
  q_status_t             sys_st, user_st;
  logic                  preempt, run_kept, pop_sys, pop_user;
  logic                  busy, done, cur_sys;
  logic [ID_BITS-1:0]    cur_id, out_id;
  logic [BURST_BITS-1:0] cur_rem;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign arrival  = accept && (s_tuser == CMD_ARRIVAL);
  assign tick_req = accept && (s_tuser == CMD_TICK);
  assign tick_go  = (state == ST_TICK) && (!m_tvalid || m_tready);

  assign in_id    = s_tdata[ID_BITS-1:0];
  assign in_burst = s_tdata[EW-1:ID_BITS];
  assign in_sys   = s_tdata[EW];
  assign in_rem   = (in_burst == '0) ? BURST_BITS'(1) : in_burst;
  assign in_entry = {in_id, in_rem};

  assign preempt  = run_valid && (run_sys == CLASS_USER) && !sys_st.empty && !user_st.full;
  assign run_kept = run_valid && !preempt;
  assign pop_sys  = tick_go && !run_kept && !sys_st.empty;
  assign pop_user = tick_go && !run_kept && sys_st.empty && !user_st.empty;

  assign sys_ctrl.push  = arrival && (in_sys == CLASS_SYSTEM);
  assign sys_ctrl.pop   = pop_sys;
  assign sys_ctrl.rd    = tick_req;
  assign user_ctrl.push = (arrival && (in_sys == CLASS_USER)) || (tick_go && preempt);
  assign user_ctrl.pop  = pop_user;
  assign user_ctrl.rd   = tick_req;
  assign user_wdata     = (state == ST_TICK) ? {run_id, run_rem} : in_entry;

  tlpqs_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_sys_q (
    .clk(clk), .rst(rst), .ctrl(sys_ctrl), .wdata(in_entry),
    .rdata(sys_rdata), .status(sys_st)
  );

  tlpqs_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_user_q (
    .clk(clk), .rst(rst), .ctrl(user_ctrl), .wdata(user_wdata),
    .rdata(user_rdata), .status(user_st)
  );

  always_comb begin
    cur_sys = run_sys;
    cur_id  = run_id;
    cur_rem = run_rem;
    if (!run_kept && !sys_st.empty) begin
      cur_sys = CLASS_SYSTEM;
      cur_id  = sys_rdata[EW-1:BURST_BITS];
      cur_rem = sys_rdata[BURST_BITS-1:0];
    end else if (!run_kept && !user_st.empty) begin
      cur_sys = CLASS_USER;
      cur_id  = user_rdata[EW-1:BURST_BITS];
      cur_rem = user_rdata[BURST_BITS-1:0];
    end
  end

  assign busy   = run_kept || !sys_st.empty || !user_st.empty;
  assign done   = busy && (cur_rem <= BURST_BITS'(1));
  assign out_id = busy ? cur_id : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      run_valid  <= 1'b0;
      run_sys    <= CLASS_USER;
      run_id     <= '0;
      run_rem    <= '0;
      clock_time <= '0;
      overflow   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (arrival && ((in_sys == CLASS_SYSTEM) ? sys_st.full : user_st.full)) begin
            overflow <= 1'b1;
          end
          if (tick_req) begin
            state <= ST_TICK;
          end
        end
        ST_TICK: begin
          if (tick_go) begin
            run_valid  <= busy && !done;
            run_sys    <= cur_sys;
            run_id     <= cur_id;
            run_rem    <= done ? '0 : cur_rem - BURST_BITS'(1);
            clock_time <= clock_time + TIME_BITS'(1);
            m_tvalid   <= 1'b1;
            m_tdata    <= OUT_W'({overflow, done, clock_time, out_id, busy});
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_sys_not_preempted: assert property (@(posedge clk) disable iff (rst)
    (tick_go && run_valid && (run_sys == CLASS_SYSTEM) && (run_rem > BURST_BITS'(1)))
    |=> run_valid && (run_sys == CLASS_SYSTEM) && (run_id == $past(run_id)))
    else $error("system task lost its slot");

  a_time_step: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> clock_time == $past(clock_time) + TIME_BITS'(1))
    else $error("time did not advance on tick");

  a_idle_means_empty: assert property (@(posedge clk) disable iff (rst)
    (tick_go && !busy) |-> (sys_st.empty && user_st.empty && !run_valid))
    else $error("idle slot with work pending");

  a_tick_then_update: assert property (@(posedge clk) disable iff (rst)
    tick_req |=> state == ST_TICK)
    else $error("tick item not processed");

endmodule

// File: sv/tlpqs_queue.sv
module tlpqs_queue #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  tlpqs_pkg::q_ctrl_t  ctrl,
  input  logic [WIDTH-1:0]    wdata,
  output logic [WIDTH-1:0]    rdata,
  output tlpqs_pkg::q_status_t status
);
  import tlpqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [SW-1:0]    tail_sum;
  logic [AW-1:0]    tail;
  logic             push_ok;

  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(DEPTH));
  assign push_ok      = ctrl.push && !status.full;

  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= wdata;
    end
    if (ctrl.rd) begin
      rdata <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (ctrl.pop) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      end
      case ({push_ok, ctrl.pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> !status.empty) else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push_ok && !ctrl.pop) |=> count == $past(count) + CW'(1))
    else $error("push did not raise count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.pop && !push_ok) |=> count == $past(count) - CW'(1))
    else $error("pop did not lower count");

endmodule
